/* src/sliding_window_maximum_unit_macros.svh */
// assertion macros for the sliding window maximum unit
// expects a clock named clk and a reset named rst in the including module
`ifndef SLIDING_WINDOW_MAXIMUM_UNIT_MACROS_SVH
`define SLIDING_WINDOW_MAXIMUM_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SWM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sliding window maximum: same-cycle check failed");

// next-cycle implication, checked outside reset
`define SWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sliding window maximum: next-cycle check failed");

`endif

/* src/swm_pkg.sv */
// shared constants, types and helpers for the sliding window maximum unit
// no dependencies
package swm_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int SIZE_BITS   = 7;
  localparam int IDX_BITS    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FILL_BITS   = $clog2(WINDOW_MAX + 1);

  // scan token handed from one cell to the next
  typedef struct packed {
    logic                   tok;
    logic [SAMPLE_BITS-1:0] pm;
  } scan_t;

  // index of the oldest cell inside the window, from the size register
  function automatic logic [IDX_BITS-1:0] last_index(input logic [SIZE_BITS-1:0] ws);
    logic [IDX_BITS-1:0] r;
    if (ws == '0) begin
      r = '0;
    end else if (32'(ws) >= WINDOW_MAX) begin
      r = IDX_BITS'(WINDOW_MAX - 1);
    end else begin
      r = IDX_BITS'(ws - SIZE_BITS'(1));
    end
    return r;
  endfunction

endpackage

/* src/swm_cell.sv */
// one cell of the window chain: holds one sample and folds it into a passing scan
// depends on swm_pkg
module swm_cell
  import swm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   shift,
  input  logic [SAMPLE_BITS-1:0] din,
  output logic [SAMPLE_BITS-1:0] dout,
  input  scan_t                  scan_in,
  output scan_t                  scan_out
);

  logic [SAMPLE_BITS-1:0] held;

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.tok <= 1'b0;
    end else begin
      scan_out.tok <= scan_in.tok;
    end
    scan_out.pm <= (held > scan_in.pm) ? held : scan_in.pm;
  end

  assign dout = held;

endmodule

/* src/sliding_window_maximum_unit.sv */
// top level of the sliding window maximum unit: cell chain, fill tracking, result buffer
// depends on swm_pkg, swm_cell and sliding_window_maximum_unit_macros.svh
//
// channel | handshake           | payload
// --------+---------------------+--------------------
// in      | in_valid / in_ready | sample, restart
// out     | out_valid/out_ready | window_max
// cfg     | cfg_we              | cfg_wdata (window_size)
//
// a sample that completes a window starts a scan that walks k cells, one per cycle;
// the result is then loaded into the output register, or parked if the output is stalled
// no new transfer is taken until the scan that a window-completing sample started has ended
// a sample that gives no result leaves in_ready high
// in_ready is low while a scan runs or a result is parked behind a stalled output
// rst clears fill count, scan tokens and handshake state; cell contents need no reset
`include "sliding_window_maximum_unit_macros.svh"

module sliding_window_maximum_unit
  import swm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [SIZE_BITS-1:0]   cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   restart,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] window_max
);

  logic [SIZE_BITS-1:0]   window_size;
  logic [FILL_BITS-1:0]   fill_count;
  logic [FILL_BITS-1:0]   fill_count_next;
  logic [FILL_BITS-1:0]   fill_base;
  logic [IDX_BITS-1:0]    ksel;
  logic                   busy;
  logic                   start;
  logic                   hold_valid;
  logic [SAMPLE_BITS-1:0] hold_data;
  logic                   in_xfer;
  logic                   emit;
  logic                   fire;
  logic                   out_free;
  logic [SAMPLE_BITS-1:0] fire_data;

  logic [SAMPLE_BITS-1:0] cell_din  [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] cell_dout [WINDOW_MAX];
  scan_t                  cell_sin  [WINDOW_MAX];
  scan_t                  cell_sout [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]  tok_vec;

  assign ksel     = last_index(window_size);
  assign in_ready = !busy && !hold_valid;
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // fill count after this sample, saturating at the chain length
  always_comb begin
    fill_base = restart ? '0 : fill_count;
    if (32'(fill_base) < WINDOW_MAX) begin
      fill_count_next = fill_base + FILL_BITS'(1);
    end else begin
      fill_count_next = fill_base;
    end
  end

  assign emit = fill_count_next >= (FILL_BITS'(ksel) + FILL_BITS'(1));

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_din[i]    = sample;
      assign cell_sin[i].tok = start;
      assign cell_sin[i].pm  = '0;
    end else begin : g_link
      assign cell_din[i]     = cell_dout[i-1];
      // the scan stops at the oldest cell of the window
      assign cell_sin[i].tok = cell_sout[i-1].tok && (IDX_BITS'(i - 1) != ksel);
      assign cell_sin[i].pm  = cell_sout[i-1].pm;
    end

    swm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (in_xfer),
      .din      (cell_din[i]),
      .dout     (cell_dout[i]),
      .scan_in  (cell_sin[i]),
      .scan_out (cell_sout[i])
    );

    assign tok_vec[i] = cell_sout[i].tok;
  end

  assign fire      = tok_vec[ksel];
  assign fire_data = cell_sout[ksel].pm;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= SIZE_BITS'(1);
      fill_count  <= '0;
      busy        <= 1'b0;
      start       <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_size <= cfg_wdata;
      end
      start <= in_xfer && emit;
      if (in_xfer) begin
        fill_count <= fill_count_next;
      end
      if (in_xfer && emit) begin
        busy <= 1'b1;
      end else if (fire) begin
        busy <= 1'b0;
      end
    end
  end

  // output register with one parking slot behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      priority if (hold_valid && out_free) begin
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end else if (fire && out_free) begin
        out_valid <= 1'b1;
      end else if (fire) begin
        hold_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hold_valid && out_free) begin
      window_max <= hold_data;
    end else if (fire && out_free) begin
      window_max <= fire_data;
    end
    if (fire && !out_free) begin
      hold_data <= fire_data;
    end
  end

  `SWM_ASSERT_NOW(a_fire_only_busy, fire, busy)
  `SWM_ASSERT_NOW(a_hold_behind_out, hold_valid, out_valid)
  `SWM_ASSERT_NEXT(a_fire_ends_scan, fire, !busy)
  `SWM_ASSERT_NOW(a_single_token, 1'b1, $onehot0(tok_vec))

endmodule

/* tb/tb_sliding_window_maximum_unit.sv */
// self-checking testbench for sliding_window_maximum_unit
// runs directed and random sample streams over many window sizes and checks every maximum
// depends on swm_pkg and the rtl of the unit
`timescale 1ns / 1ps

module tb_sliding_window_maximum_unit
  import swm_pkg::*;
();

  localparam int CLK_HALF = 4;
  localparam int SETTLE   = WINDOW_MAX + 16;
  localparam int LIMIT    = 1_000_000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [SIZE_BITS-1:0]   cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] sample = '0;
  logic                   restart = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SAMPLE_BITS-1:0] window_max;

  // copy of the window kept by the testbench
  logic [SAMPLE_BITS-1:0] shadow_store [WINDOW_MAX];
  int                     shadow_fill;
  int                     shadow_slot;
  logic [SIZE_BITS-1:0]   shadow_size;
  logic [SAMPLE_BITS-1:0] expected_max_q [$];

  int errors         = 0;
  int samples_sent   = 0;
  int restarts_sent  = 0;
  int maxima_checked = 0;
  int size_writes    = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;

  sliding_window_maximum_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .window_max (window_max)
  );

  always #CLK_HALF clk = ~clk;

  function automatic int window_span(input logic [SIZE_BITS-1:0] ws);
    int span;
    span = int'(ws);
    if (span == 0) begin
      span = 1;
    end else if (span > WINDOW_MAX) begin
      span = WINDOW_MAX;
    end
    return span;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    errors++;
  endtask

  // restart clears only the fill count, the write slot keeps wrapping
  task automatic predict_window_max(input logic [SAMPLE_BITS-1:0] value, input logic clear);
    int span;
    int cur;
    logic [SAMPLE_BITS-1:0] best;
    if (clear) begin
      shadow_fill = 0;
    end
    cur = shadow_slot;
    shadow_store[cur] = value;
    shadow_slot = (cur + 1) % WINDOW_MAX;
    if (shadow_fill < WINDOW_MAX) begin
      shadow_fill++;
    end
    span = window_span(shadow_size);
    if (shadow_fill >= span) begin
      best = '0;
      for (int i = 0; i < span; i++) begin
        if (shadow_store[(cur + WINDOW_MAX - i) % WINDOW_MAX] > best) begin
          best = shadow_store[(cur + WINDOW_MAX - i) % WINDOW_MAX];
        end
      end
      expected_max_q = {expected_max_q, best};
    end
  endtask

  // tracks config writes and input transfers, checks output transfers
  always @(posedge clk) begin
    logic [SAMPLE_BITS-1:0] want;
    if (rst) begin
      shadow_fill = 0;
      shadow_slot = 0;
      shadow_size = SIZE_BITS'(1);
    end else begin
      if (cfg_we) begin
        shadow_size = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        samples_sent++;
        if (restart) begin
          restarts_sent++;
        end
        predict_window_max(sample, restart);
      end
      if (out_valid && out_ready) begin
        if (expected_max_q.size() == 0) begin
          report_mismatch($sformatf("window_max %h with no result pending", window_max));
        end else begin
          want = expected_max_q.pop_front();
          maxima_checked++;
          if (window_max !== want) begin
            report_mismatch($sformatf("window_max %h, expected %h", window_max, want));
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("** sliding_window_maximum_unit: FAILED **");
    $finish;
  end

  // one input transfer; returns just after the accepting edge
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] value, input logic clear);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    sample   = value;
    restart  = clear;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_max_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // the unit may still be absorbing a sample with no result, so let it settle first
  task automatic write_window_size(input logic [SIZE_BITS-1:0] ws);
    wait_results_drained();
    repeat (SETTLE) @(negedge clk);
    cfg_wdata = ws;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    size_writes++;
  endtask

  // window size after reset is 1, so every sample is its own maximum
  task automatic test_default_size();
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h5A5A, 1'b1);
    send_sample(16'hA5A5, 1'b0);
  endtask

  task automatic test_directed_windows();
    // size zero behaves as one
    write_window_size(SIZE_BITS'(0));
    send_sample(16'h1234, 1'b0);
    send_sample(16'h0001, 1'b0);
    // peak leaves the window, restart empties it mid-stream
    write_window_size(SIZE_BITS'(3));
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0002, 1'b0);
    send_sample(16'h0003, 1'b1);
    send_sample(16'h0004, 1'b0);
    send_sample(16'h0000, 1'b0);
    // shrink then grow past the current fill
    write_window_size(SIZE_BITS'(2));
    send_sample(16'h0007, 1'b0);
    write_window_size(SIZE_BITS'(5));
    send_sample(16'h0006, 1'b0);
    send_sample(16'h0001, 1'b0);
    write_window_size(SIZE_BITS'(1));
    send_sample(16'hFFFF, 1'b1);
  endtask

  // sizes at and above the store depth, including a full wrap of the write slot
  task automatic test_full_window();
    write_window_size(SIZE_BITS'(127));
    for (int i = 0; i < 70; i++) begin
      send_sample(SAMPLE_BITS'($urandom_range(65535)), i == 0);
      if (i == 35) begin
        wait_results_drained();
      end
    end
    write_window_size(SIZE_BITS'(WINDOW_MAX));
    for (int i = 0; i < 10; i++) begin
      send_sample(SAMPLE_BITS'($urandom_range(65535)), 1'b0);
    end
    write_window_size(SIZE_BITS'(WINDOW_MAX + 1));
    for (int i = 0; i < 10; i++) begin
      send_sample(SAMPLE_BITS'($urandom_range(65535)), 1'b0);
    end
  endtask

  task automatic run_random_phase(input int send_pct, input int recv_pct, input int n_items);
    int sent;
    int r;
    int batch;
    int style;
    logic [SIZE_BITS-1:0]   ws;
    logic [SAMPLE_BITS-1:0] ramp;
    logic [SAMPLE_BITS-1:0] value;
    logic                   clear;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      // mostly short windows, a few deep ones and out-of-range sizes
      r = $urandom_range(99);
      if (r < 55) begin
        ws = SIZE_BITS'($urandom_range(1, 8));
      end else if (r < 80) begin
        ws = SIZE_BITS'($urandom_range(9, 32));
      end else if (r < 92) begin
        ws = SIZE_BITS'($urandom_range(33, WINDOW_MAX));
      end else if (r < 95) begin
        ws = SIZE_BITS'(0);
      end else begin
        ws = SIZE_BITS'($urandom_range(WINDOW_MAX + 1, 127));
      end
      write_window_size(ws);
      batch = window_span(ws) + $urandom_range(10, 40);
      style = $urandom_range(3);
      ramp  = SAMPLE_BITS'($urandom_range(65535));
      for (int j = 0; j < batch; j++) begin
        case (style)
          0: begin
            value = SAMPLE_BITS'($urandom_range(65535));
          end
          1: begin
            value = SAMPLE_BITS'($urandom_range(15));
          end
          2: begin
            value = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          end
          default: begin
            // falling ramp: the maximum leaves the window every step until the ramp wraps around
            ramp  = ramp - SAMPLE_BITS'($urandom_range(1, 300));
            value = ramp;
          end
        endcase
        clear = (j == 0 && $urandom_range(2) == 0) || ($urandom_range(99) < 3);
        send_sample(value, clear);
        if ($urandom_range(63) == 0) begin
          wait_results_drained();
        end
      end
      sent += batch;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 60;
    test_default_size();
    test_directed_windows();
    test_full_window();
    run_random_phase(20, 60, 355);
    run_random_phase(60, 20, 355);
    run_random_phase(0, 0, 355);
    wait_results_drained();
    repeat (SETTLE) @(negedge clk);
    $display("covered %0d samples with %0d restarts over %0d window size writes",
             samples_sent, restarts_sent, size_writes);
    $display("checked %0d window maxima, %0d mismatches", maxima_checked, errors);
    if (errors == 0) begin
      $display("** sliding_window_maximum_unit: PASSED **");
    end else begin
      $display("** sliding_window_maximum_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* sliding_window_maximum_unit.f */
+incdir+src
src/swm_pkg.sv
src/swm_cell.sv
src/sliding_window_maximum_unit.sv
tb/tb_sliding_window_maximum_unit.sv
